// ----- rtl/slot_free_list_allocator_top_assert.svh -----
// assertion macros for the rtl of the slot allocator top
`ifndef SLOT_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH
`define SLOT_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define SFLA_ASSERT_NOW(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cond)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define SFLA_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ----- rtl/sfla_pkg.sv -----
// ----------------------------------------------------------------------------
// sfla_pkg
// Types, codes and constants shared by the slot allocator modules.
// ----------------------------------------------------------------------------
package sfla_pkg;

    // pool size default and fixed field widths
    localparam int SLOTS_DEFAULT = 1024;
    localparam int CAP_W         = 11;
    localparam int CAP_RESET     = 1024;
    localparam int SLOT_W        = 10;
    localparam int REQ_W         = 2;
    localparam int STATUS_W      = 2;
    localparam int S_TDATA_W     = 16;
    localparam int M_TDATA_W     = 24;

    // request kinds
    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_INIT    = 2'd2,
        REQ_NONE    = 2'd3
    } req_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_RANGE     = 2'd2
    } status_t;

    // one result item
    typedef struct packed {
        status_t             status;
        logic [SLOT_W-1:0]   slot;
        logic [CAP_W-1:0]    free_count;
    } res_t;

endpackage

// ----- rtl/sfla_link_mem.sv -----
// ----------------------------------------------------------------------------
// sfla_link_mem
// Link store of the free list: one write port, one read port, registered
// read data that appears in the cycle after the read.
// ----------------------------------------------------------------------------
module sfla_link_mem #(
    parameter int SLOTS = sfla_pkg::SLOTS_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [$clog2(SLOTS)-1:0]   wr_addr,
    input  logic [$clog2(SLOTS):0]     wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(SLOTS)-1:0]   rd_addr,
    output logic [$clog2(SLOTS):0]     rd_data
);
    import sfla_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int LW = IW + 1;

    logic [LW-1:0] mem [SLOTS];
    logic [LW-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/slot_free_list_allocator_top.sv -----
// ----------------------------------------------------------------------------
// slot_free_list_allocator_top
// Pool of SLOTS slots kept as a last-in-first-out linked free list in a
// synchronous link memory, with allocate, release and initialise requests.
// ----------------------------------------------------------------------------
// Timing: one request at a time. Release, rejected requests and the no-op
// kind are answered straight from idle. Allocate waits in ST_ALLOC, since the
// link of the head slot comes out of the link memory in the cycle after the
// read. Initialise writes one link per cycle over the slots in use (limited
// to SLOTS), and answers straight from idle when the capacity is zero.
// After reset a fill pass writes every link with its successor. s_tready
// stays low during that pass, while configuration writes are taken. The
// result sits in an output register. A second register holds a result while
// the first still waits, and the input stays blocked until the held result
// has moved into the output register.
module slot_free_list_allocator_top #(
    parameter int SLOTS = sfla_pkg::SLOTS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration: capacity in use
    input  logic                          cfg_wr_en,
    input  logic [sfla_pkg::CAP_W-1:0]    cfg_wr_data,
    // request stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sfla_pkg::S_TDATA_W-1:0] s_tdata, // [9:0] slot_in
    input  logic [sfla_pkg::REQ_W-1:0]    s_tuser,  // [1:0] req_type
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sfla_pkg::M_TDATA_W-1:0] m_tdata, // [9:0] slot_out, [20:10] free_count
    output logic [sfla_pkg::STATUS_W-1:0] m_tuser   // [1:0] status
);
    import sfla_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int LW = IW + 1;
    localparam int CW = (LW > CAP_W) ? LW : CAP_W;
    localparam int FREE_RESET = (CAP_RESET > SLOTS) ? SLOTS : CAP_RESET;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_IDLE,
        ST_ALLOC,
        ST_INIT,
        ST_HOLD
    } state_t;

    state_t            state_reg, state_next;
    logic [CAP_W-1:0]  cap_reg;
    logic [LW-1:0]     head_reg, head_next;
    logic [LW-1:0]     free_total_reg, free_total_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [IW-1:0]     got_reg, got_next;
    res_t              out_reg, out_next;
    res_t              pend_reg, pend_next;
    logic              m_valid_reg, m_valid_next;

    // combinational request handling
    logic              s_accept;
    req_t              req;
    logic [CW-1:0]     cap_ext, cap_eff, head_ext, slot_ext;
    logic [LW-1:0]     free_inc, free_dec;
    logic              out_free;
    logic              res_fire;
    res_t              res;
    logic              rel_ok;

    // link memory port
    logic              mem_we, mem_re;
    logic [IW-1:0]     mem_waddr, mem_raddr;
    logic [LW-1:0]     mem_wdata, mem_rdata;

    sfla_link_mem #(
        .SLOTS(SLOTS)
    ) u_link_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // effective capacity and operand views
    assign cap_ext  = CW'(cap_reg);
    assign cap_eff  = (cap_ext > CW'(SLOTS)) ? CW'(SLOTS) : cap_ext;
    assign head_ext = CW'(head_reg);
    assign slot_ext = CW'(s_tdata[SLOT_W-1:0]);
    assign req      = req_t'(s_tuser);
    assign free_inc = (free_total_reg < LW'(SLOTS)) ? free_total_reg + LW'(1) : free_total_reg;
    assign free_dec = (free_total_reg != '0) ? free_total_reg - LW'(1) : free_total_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign rel_ok   = s_accept && (req == REQ_RELEASE) && (slot_ext < cap_eff);

    // next-state logic
    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        free_total_next = free_total_reg;
        idx_next        = idx_reg;
        got_next        = got_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = LW'(idx_reg) + LW'(1);
        mem_re          = 1'b0;
        mem_raddr       = IW'(head_reg);
        res_fire        = 1'b0;
        res.status      = ST_OK;
        res.slot        = '0;
        res.free_count  = CAP_W'(free_total_reg);

        case (state_reg)
            // post-reset fill of every link
            ST_FILL: begin
                mem_we = 1'b1;
                if (idx_reg == IW'(SLOTS - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    case (req)
                        REQ_ALLOC: begin
                            if (head_ext >= cap_eff) begin
                                res_fire   = 1'b1;
                                res.status = ST_EXHAUSTED;
                            end else begin
                                mem_re     = 1'b1;
                                got_next   = IW'(head_reg);
                                state_next = ST_ALLOC;
                            end
                        end
                        REQ_RELEASE: begin
                            res_fire = 1'b1;
                            if (slot_ext >= cap_eff) begin
                                res.status = ST_RANGE;
                            end else begin
                                mem_we          = 1'b1;
                                mem_waddr       = IW'(slot_ext);
                                mem_wdata       = head_reg;
                                head_next       = LW'(slot_ext);
                                free_total_next = free_inc;
                                res.free_count  = CAP_W'(free_inc);
                            end
                        end
                        REQ_INIT: begin
                            idx_next = '0;
                            if (cap_eff == '0) begin
                                head_next       = '0;
                                free_total_next = '0;
                                res_fire        = 1'b1;
                                res.free_count  = '0;
                            end else begin
                                state_next = ST_INIT;
                            end
                        end
                        default: begin
                            res_fire = 1'b1;
                        end
                    endcase
                end
            end
            // link of the old head is back from memory
            ST_ALLOC: begin
                head_next       = mem_rdata;
                free_total_next = free_dec;
                res_fire        = 1'b1;
                res.slot        = SLOT_W'(got_reg);
                res.free_count  = CAP_W'(free_dec);
            end
            // rebuild chain over the slots in use
            ST_INIT: begin
                mem_we = 1'b1;
                if (CW'(idx_reg) == cap_eff - CW'(1)) begin
                    head_next       = '0;
                    free_total_next = LW'(cap_eff);
                    res_fire        = 1'b1;
                    res.free_count  = CAP_W'(cap_eff);
                end else begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            ST_HOLD: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // result goes to the output register, or waits beside it
        out_next     = out_reg;
        pend_next    = pend_reg;
        m_valid_next = m_valid_reg && !m_tready;
        if (res_fire) begin
            if (out_free) begin
                out_next     = res;
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end else begin
                pend_next  = res;
                state_next = ST_HOLD;
            end
        end else if ((state_reg == ST_HOLD) && m_tready) begin
            out_next     = pend_reg;
            m_valid_next = 1'b1;
        end
    end

    // state and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_FILL;
            cap_reg        <= CAP_W'(CAP_RESET);
            head_reg       <= '0;
            free_total_reg <= LW'(FREE_RESET);
            idx_reg        <= '0;
            got_reg        <= '0;
            out_reg        <= '0;
            pend_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            free_total_reg <= free_total_next;
            idx_reg        <= idx_next;
            got_reg        <= got_next;
            out_reg        <= out_next;
            pend_reg       <= pend_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = M_TDATA_W'({out_reg.free_count, out_reg.slot});

    // checks
    `include "slot_free_list_allocator_top_assert.svh"

    `SFLA_ASSERT_NEXT(a_alloc_one_wait, state_reg == ST_ALLOC,
        state_reg != ST_ALLOC, "allocate read stalled")
    `SFLA_ASSERT_NOW(a_hold_has_out, state_reg == ST_HOLD, m_valid_reg,
        "held result without output")
    `SFLA_ASSERT_NEXT(a_release_head, rel_ok,
        head_reg == LW'($past(s_tdata[SLOT_W-1:0])), "release did not move head")
    `SFLA_ASSERT_NEXT(a_alloc_count, (state_reg == ST_ALLOC) && (free_total_reg != '0),
        free_total_reg == $past(free_total_reg) - LW'(1), "allocate count wrong")

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the linked free-list slot allocator. A shadow of
// the free list (link store, head, free count) predicts each grant, and every
// result transfer is compared field by field with the oldest prediction.
// Directed requests cover the corner cases, then random phases with
// different capacities run mostly well-formed allocate and release traffic.
// ----------------------------------------------------------------------------
module testbench;
    import sfla_pkg::*;

    localparam int POOL        = SLOTS_DEFAULT;
    localparam int ITEM_TARGET = 1000;
    localparam int PHASE_ITEMS = 100;
    localparam int STALL_LIMIT = 10000;
    localparam int MAX_SHOWN   = 10;

    typedef struct packed {
        req_t              kind;
        logic [SLOT_W-1:0] slot;
    } request_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0; // [9:0] slot_in
    logic [REQ_W-1:0]     s_tuser     = '0; // [1:0] req_type
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // [9:0] slot_out, [20:10] free_count
    logic [STATUS_W-1:0]  m_tuser;          // [1:0] status

    // shadow of the free list
    logic [CAP_W-1:0] shadow_link [POOL];
    logic [CAP_W-1:0] shadow_head;
    logic [CAP_W-1:0] shadow_free;
    logic [CAP_W-1:0] shadow_cap;

    res_t     expected_grants[$];
    request_t request_queue[$];
    int       issued      = 0;
    int       mismatches  = 0;
    int       stall_count = 0;
    bit       req_fire_seen = 1'b0;
    bit       res_fire_seen = 1'b0;
    bit       no_idle       = 1'b0;
    int       send_gap      = 0;
    int       take_gap      = 0;

    // stimulus-side guess of the free list, used to pick sensible releases
    int plan_free[$];
    int plan_held[$];

    slot_free_list_allocator_top #(.SLOTS(POOL)) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // clock and reset
    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;
    end

    function automatic int usable_slots();
        return (int'(shadow_cap) > POOL) ? POOL : int'(shadow_cap);
    endfunction

    // advance the shadow list by one request and return the grant it causes
    function automatic res_t grant_for(request_t rq);
        res_t r;
        int   lim;
        lim          = usable_slots();
        r.status     = ST_OK;
        r.slot       = '0;
        case (rq.kind)
            REQ_ALLOC: begin
                if (int'(shadow_head) >= lim) begin
                    r.status = ST_EXHAUSTED;
                end else begin
                    r.slot      = shadow_head[SLOT_W-1:0];
                    shadow_head = shadow_link[shadow_head[SLOT_W-1:0]];
                    if (shadow_free > 0) shadow_free--;
                end
            end
            REQ_RELEASE: begin
                if (int'(rq.slot) >= lim) begin
                    r.status = ST_RANGE;
                end else begin
                    shadow_link[rq.slot] = shadow_head;
                    shadow_head          = CAP_W'(rq.slot);
                    if (int'(shadow_free) < POOL) shadow_free++;
                end
            end
            REQ_INIT: begin
                for (int i = 0; i < lim; i++) shadow_link[i] = CAP_W'(i + 1);
                shadow_head = '0;
                shadow_free = CAP_W'(lim);
            end
            default: ;
        endcase
        r.free_count = shadow_free;
        return r;
    endfunction

    function automatic void log_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_SHOWN) $display("%s", msg);
    endfunction

    function automatic int idle_draw();
        if (no_idle || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 10);
    endfunction

    // monitor: config writes, request transfers and result checks
    always @(posedge aclk) begin
        res_t got;
        res_t want;
        bit   busy;
        bit   fired;
        if (!aresetn) begin
            for (int i = 0; i < POOL; i++) shadow_link[i] = CAP_W'(i + 1);
            shadow_cap  = CAP_W'(CAP_RESET);
            shadow_head = '0;
            shadow_free = CAP_W'(usable_slots());
            req_fire_seen <= 1'b0;
            res_fire_seen <= 1'b0;
            stall_count   <= 0;
        end else begin
            if (cfg_wr_en) shadow_cap = cfg_wr_data;
            // check the result before queuing a new prediction
            if (m_tvalid && m_tready) begin
                got.status     = status_t'(m_tuser);
                got.slot       = m_tdata[SLOT_W-1:0];
                got.free_count = m_tdata[SLOT_W +: CAP_W];
                if (expected_grants.size() == 0) begin
                    log_mismatch($sformatf("unexpected grant: status %0d slot %0d free %0d",
                        got.status, got.slot, got.free_count));
                end else begin
                    want = expected_grants.pop_front();
                    if (got.status != want.status || got.slot != want.slot ||
                        got.free_count != want.free_count) begin
                        log_mismatch($sformatf(
                            "grant mismatch: want status %0d slot %0d free %0d, got %0d %0d %0d",
                            want.status, want.slot, want.free_count,
                            got.status, got.slot, got.free_count));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_grants.push_back(grant_for(request_t'({s_tuser, s_tdata[SLOT_W-1:0]})));
            end
            busy  = s_tvalid || expected_grants.size() != 0;
            fired = (s_tvalid && s_tready) || (m_tvalid && m_tready);
            stall_count   <= (busy && !fired) ? stall_count + 1 : 0;
            req_fire_seen <= s_tvalid && s_tready;
            res_fire_seen <= m_tvalid && m_tready;
        end
    end

    // request driver
    always @(negedge aclk) begin
        request_t rq;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || req_fire_seen) begin
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (request_queue.size() != 0) begin
                rq = request_queue.pop_front();
                s_tuser  <= rq.kind;
                s_tdata  <= S_TDATA_W'(rq.slot);
                s_tvalid <= 1'b1;
                send_gap = idle_draw();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver with random back-pressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (res_fire_seen) take_gap = idle_draw();
            if (take_gap > 0) begin
                take_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with pending work and no transfer
    initial begin
        while (stall_count < STALL_LIMIT) @(posedge aclk);
        $display("tb: failure");
        $finish;
    end

    task automatic push_request(input req_t kind, input logic [SLOT_W-1:0] slot);
        request_t rq;
        rq.kind = kind;
        rq.slot = slot;
        request_queue.push_back(rq);
        issued++;
    endtask

    // wait until every request went out and every grant came back
    task automatic settle();
        do @(negedge aclk);
        while (request_queue.size() != 0 || s_tvalid || expected_grants.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_capacity(input int value);
        settle();
        cfg_wr_data = CAP_W'(value);
        cfg_wr_en   = 1'b1;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        @(posedge aclk);
    endtask

    task automatic plan_init(input int lim);
        push_request(REQ_INIT, SLOT_W'($urandom));
        plan_free.delete();
        plan_held.delete();
        for (int i = 0; i < lim; i++) plan_free.push_back(i);
    endtask

    // stimulus
    initial begin
        int cap;
        int lim;
        int pick;
        int idx;
        int slot;

        @(posedge aresetn);
        @(posedge aclk);

        // reset capacity: pops, double release, no-op kind, count saturation
        push_request(REQ_ALLOC, SLOT_W'(0));
        push_request(REQ_ALLOC, SLOT_W'(1023));
        push_request(REQ_RELEASE, SLOT_W'(1023));
        push_request(REQ_RELEASE, SLOT_W'(0));
        push_request(REQ_RELEASE, SLOT_W'(0));
        push_request(REQ_ALLOC, SLOT_W'(0));
        push_request(REQ_ALLOC, SLOT_W'(0));
        push_request(REQ_ALLOC, SLOT_W'(0));
        push_request(REQ_NONE, SLOT_W'(1023));
        push_request(REQ_INIT, SLOT_W'(0));
        push_request(REQ_RELEASE, SLOT_W'(1023));
        push_request(REQ_ALLOC, SLOT_W'(1023));

        // two slots: exhaustion, head at capacity, release out of range
        write_capacity(2);
        push_request(REQ_ALLOC, SLOT_W'(0));
        push_request(REQ_ALLOC, SLOT_W'(0));
        push_request(REQ_ALLOC, SLOT_W'(0));
        push_request(REQ_RELEASE, SLOT_W'(2));
        push_request(REQ_RELEASE, SLOT_W'(1));
        push_request(REQ_INIT, SLOT_W'(0));

        // zero capacity: allocate and release rejected, initialise gives an empty list
        write_capacity(0);
        push_request(REQ_ALLOC, SLOT_W'(0));
        push_request(REQ_RELEASE, SLOT_W'(0));
        push_request(REQ_INIT, SLOT_W'(0));
        push_request(REQ_ALLOC, SLOT_W'(0));

        // capacity above the pool saturates to the pool size
        write_capacity(2047);
        push_request(REQ_INIT, SLOT_W'(0));
        push_request(REQ_RELEASE, SLOT_W'(1023));
        push_request(REQ_ALLOC, SLOT_W'(0));

        // random phases, each with its own capacity
        while (issued < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: cap = $urandom_range(1, 8);
                4, 5:       cap = $urandom_range(9, 1023);
                6, 9:       cap = POOL;
                7:          cap = $urandom_range(1025, 2047);
                default:    cap = $urandom_range(1, 3);
            endcase
            write_capacity(cap);
            lim     = (cap > POOL) ? POOL : cap;
            no_idle = ($urandom_range(0, 4) == 0);
            plan_free.delete();
            plan_held.delete();
            if ($urandom_range(0, 3) != 0) plan_init(lim);
            repeat (PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    push_request(REQ_ALLOC, SLOT_W'($urandom));
                    if (plan_free.size() != 0) plan_held.push_back(plan_free.pop_front());
                end else if (pick < 80) begin
                    // release a slot believed to be held, else any slot in range
                    if (plan_held.size() != 0) begin
                        idx  = $urandom_range(0, plan_held.size() - 1);
                        slot = plan_held[idx];
                        plan_held.delete(idx);
                        plan_free.push_front(slot);
                    end else begin
                        slot = $urandom_range(0, lim - 1);
                    end
                    push_request(REQ_RELEASE, SLOT_W'(slot));
                end else if (pick < 88) begin
                    push_request(REQ_RELEASE, SLOT_W'($urandom));
                end else if (pick < 93) begin
                    plan_init(lim);
                end else begin
                    push_request(REQ_NONE, SLOT_W'($urandom));
                end
            end
        end

        settle();
        repeat (20) @(posedge aclk);
        if (expected_grants.size() != 0) begin
            log_mismatch($sformatf("%0d grants never arrived", expected_grants.size()));
        end
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
